@@ hdl/gbgs_pkg.sv @@
// Shared codes for the cost-weighted grid search block.
package gbgs_pkg;

   localparam logic [1:0] ACT_WRITE  = 2'd0;
   localparam logic [1:0] ACT_SEARCH = 2'd1;
   localparam logic [1:0] ACT_READ   = 2'd2;

   localparam logic KIND_SEARCH = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   localparam logic [1:0] REG_ROWS = 2'd0;
   localparam logic [1:0] REG_COLS = 2'd1;

   localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
   localparam logic [47:0] ONE_Q47 = 48'h8000_0000_0000;
   localparam logic [16:0] ONE_Q16 = 17'h1_0000;

   typedef struct packed {
      logic [31:0] prob;
      logic [15:0] pod;
      logic [15:0] cost;
   } cell_type;

endpackage

@@ hdl/gbgs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module gbgs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/greedy_bayesian_grid_search.sv @@
// A write item stores its cell when accepted; a read item registers the cell, then delivers it.
// A search scans the in-use grid, scoring and comparing each cell, then updates each cell
// in turn through a restoring divider that forms a 31-bit quotient.
// One item is in work at a time; all cell state sits in one RAM port pair.
// Reset clears the control state and sets both grid sizes to 16; the cell stores are
// undefined until written and are not cleared.
module greedy_bayesian_grid_search #(
   parameter int MAX_ROWS = 16,
   parameter int MAX_COLS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [3:0]  req_cell_row,
   input  logic [3:0]  req_cell_col,
   input  logic [31:0] req_cell_prior,
   input  logic [15:0] req_cell_pod,
   input  logic [15:0] req_cell_cost,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [3:0]  rsp_searched_row,
   output logic [3:0]  rsp_searched_col,
   output logic [31:0] rsp_detection_prob,
   output logic [31:0] rsp_cell_posterior,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [4:0]  csr_data
);
   import gbgs_pkg::*;

   localparam int CELLS = MAX_ROWS * MAX_COLS;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int RNW   = $clog2(MAX_ROWS + 1);
   localparam int CNW   = $clog2(MAX_COLS + 1);
   localparam int ACCW  = 48 + AW;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_READ     = 4'd1;
   localparam logic [3:0] S_SC_RD    = 4'd2;
   localparam logic [3:0] S_SC_DAT   = 4'd3;
   localparam logic [3:0] S_SC_MUL   = 4'd4;
   localparam logic [3:0] S_SC_CMP   = 4'd5;
   localparam logic [3:0] S_BEST_RD  = 4'd6;
   localparam logic [3:0] S_BEST_DAT = 4'd7;
   localparam logic [3:0] S_BEST_DEN = 4'd8;
   localparam logic [3:0] S_UP_RD    = 4'd9;
   localparam logic [3:0] S_UP_DAT   = 4'd10;
   localparam logic [3:0] S_UP_CHK   = 4'd11;
   localparam logic [3:0] S_UP_DIV   = 4'd12;
   localparam logic [3:0] S_UP_WR    = 4'd13;
   localparam logic [3:0] S_UP_ACC   = 4'd14;
   localparam logic [3:0] S_DONE     = 4'd15;

   logic [3:0]      state_ff, state_in;
   logic [4:0]      rows_ff, rows_in, cols_ff, cols_in;
   logic [RNW-1:0]  nr_ff, nr_in, r_ff, r_in, best_r_ff, best_r_in;
   logic [CNW-1:0]  nc_ff, nc_in, c_ff, c_in, best_c_ff, best_c_in;
   logic            have_ff, have_in;
   logic [47:0]     best_s_ff, best_s_in, s_ff, s_in, den_ff, den_in;
   logic [15:0]     best_k_ff, best_k_in, k_ff, k_in, ds_ff, ds_in;
   logic [63:0]     pa_ff, pa_in, pb_ff, pb_in;
   logic [48:0]     rem_ff, rem_in;
   logic [30:0]     frac_ff, frac_in;
   logic [4:0]      cnt_ff, cnt_in;
   logic [31:0]     newp_ff, newp_in, post_ff, post_in;
   logic [15:0]     hold_pod_ff, hold_pod_in, hold_cost_ff, hold_cost_in;
   logic [47:0]     prod_ff, prod_in;
   logic [ACCW-1:0] acc_ff, acc_in;
   logic            kind_ff, kind_in, zero_ff, zero_in;
   logic [3:0]      res_row_ff, res_row_in, res_col_ff, res_col_in;
   logic            rsp_valid_ff, rsp_valid_in, rsp_kind_ff, rsp_kind_in;
   logic [3:0]      rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic [31:0]     rsp_det_ff, rsp_det_in, rsp_post_ff, rsp_post_in;

   logic            mem_we, mem_re;
   logic [AW-1:0]   mem_waddr, mem_raddr, req_addr, cur_addr, best_addr;
   cell_type        mem_wdata, mem_rdata, req_cell;
   logic            req_fire, req_inside, last_cell;
   logic [48:0]     rem_shift;
   logic [ACCW-17:0] det_full;
   logic [31:0]     det_sat;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign req_inside = (32'(req_cell_row) < MAX_ROWS) && (32'(req_cell_col) < MAX_COLS);
   assign req_addr   = AW'(32'(req_cell_row) * MAX_COLS + 32'(req_cell_col));
   assign cur_addr   = AW'(32'(r_ff) * MAX_COLS + 32'(c_ff));
   assign best_addr  = AW'(32'(best_r_ff) * MAX_COLS + 32'(best_c_ff));
   assign last_cell  = (r_ff == nr_ff - RNW'(1)) && (c_ff == nc_ff - CNW'(1));

   assign req_cell.prob = (req_cell_prior > ONE_Q31) ? ONE_Q31 : req_cell_prior;
   assign req_cell.pod  = req_cell_pod;
   assign req_cell.cost = (req_cell_cost == 16'd0) ? 16'd1 : req_cell_cost;

   assign rem_shift = {rem_ff[47:0], 1'b0};
   assign det_full  = acc_ff[ACCW-1:16];
   assign det_sat   = (det_full > (ACCW-16)'(ONE_Q31)) ? ONE_Q31 : det_full[31:0];

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = req_addr;
      mem_wdata = req_cell;
      mem_re    = 1'b0;
      mem_raddr = cur_addr;
      if (state_ff == S_UP_WR) begin
         mem_we    = 1'b1;
         mem_waddr = cur_addr;
         mem_wdata = '{prob: newp_ff, pod: hold_pod_ff, cost: hold_cost_ff};
      end else if (req_fire && req_action == ACT_WRITE && req_inside) begin
         mem_we = 1'b1;
      end
      if (req_fire && req_action == ACT_READ) begin
         mem_re    = 1'b1;
         mem_raddr = req_addr;
      end else if (state_ff == S_SC_RD || state_ff == S_UP_RD) begin
         mem_re = 1'b1;
      end else if (state_ff == S_BEST_RD) begin
         mem_re    = 1'b1;
         mem_raddr = best_addr;
      end
   end

   gbgs_ram #(.WIDTH($bits(cell_type)), .DEPTH(CELLS)) u_cells (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_comb begin
      state_in = state_ff;
      rows_in = rows_ff;  cols_in = cols_ff;
      nr_in = nr_ff;  nc_in = nc_ff;  r_in = r_ff;  c_in = c_ff;
      best_r_in = best_r_ff;  best_c_in = best_c_ff;  have_in = have_ff;
      best_s_in = best_s_ff;  best_k_in = best_k_ff;  s_in = s_ff;  k_in = k_ff;
      den_in = den_ff;  ds_in = ds_ff;  pa_in = pa_ff;  pb_in = pb_ff;
      rem_in = rem_ff;  frac_in = frac_ff;  cnt_in = cnt_ff;
      newp_in = newp_ff;  post_in = post_ff;
      hold_pod_in = hold_pod_ff;  hold_cost_in = hold_cost_ff;
      prod_in = prod_ff;  acc_in = acc_ff;
      kind_in = kind_ff;  zero_in = zero_ff;  res_row_in = res_row_ff;  res_col_in = res_col_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in = rsp_kind_ff;  rsp_row_in = rsp_row_ff;  rsp_col_in = rsp_col_ff;
      rsp_det_in = rsp_det_ff;  rsp_post_in = rsp_post_ff;

      if (csr_valid && csr_ready) begin
         if (csr_index == REG_ROWS) rows_in = csr_data;
         if (csr_index == REG_COLS) cols_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_action == ACT_READ) begin
                  kind_in    = KIND_READ;
                  res_row_in = req_cell_row;
                  res_col_in = req_cell_col;
                  zero_in    = !req_inside;
                  state_in   = S_READ;
               end else if (req_action == ACT_SEARCH) begin
                  // The grid size is clamped to 1..MAX once per search.
                  nr_in = (rows_ff == 5'd0) ? RNW'(1) :
                          (32'(rows_ff) > MAX_ROWS) ? RNW'(MAX_ROWS) : RNW'(rows_ff);
                  nc_in = (cols_ff == 5'd0) ? CNW'(1) :
                          (32'(cols_ff) > MAX_COLS) ? CNW'(MAX_COLS) : CNW'(cols_ff);
                  r_in     = '0;
                  c_in     = '0;
                  have_in  = 1'b0;
                  kind_in  = KIND_SEARCH;
                  state_in = S_SC_RD;
               end
            end
         end
         S_READ: begin
            post_in  = zero_ff ? 32'd0 : mem_rdata.prob;
            state_in = S_DONE;
         end
         S_SC_RD: state_in = S_SC_DAT;
         S_SC_DAT: begin
            s_in     = mem_rdata.prob * mem_rdata.pod;
            k_in     = mem_rdata.cost;
            state_in = S_SC_MUL;
         end
         S_SC_MUL: begin
            pa_in    = s_ff * best_k_ff;
            pb_in    = best_s_ff * k_ff;
            state_in = S_SC_CMP;
         end
         S_SC_CMP: begin
            if (!have_ff || pa_ff > pb_ff) begin
               have_in   = 1'b1;
               best_s_in = s_ff;
               best_k_in = k_ff;
               best_r_in = r_ff;
               best_c_in = c_ff;
            end
            if (last_cell) begin
               state_in = S_BEST_RD;
            end else begin
               state_in = S_SC_RD;
            end
            if (c_ff == nc_ff - CNW'(1)) begin
               c_in = '0;
               r_in = r_ff + RNW'(1);
            end else begin
               c_in = c_ff + CNW'(1);
            end
         end
         S_BEST_RD: state_in = S_BEST_DAT;
         S_BEST_DAT: begin
            s_in     = mem_rdata.prob * mem_rdata.pod;
            ds_in    = mem_rdata.pod;
            state_in = S_BEST_DEN;
         end
         S_BEST_DEN: begin
            den_in   = ONE_Q47 - s_ff;
            r_in     = '0;
            c_in     = '0;
            acc_in   = '0;
            state_in = S_UP_RD;
         end
         S_UP_RD: state_in = S_UP_DAT;
         S_UP_DAT: begin
            rem_in = mem_rdata.prob *
                     ((cur_addr == best_addr) ? (ONE_Q16 - 17'(ds_ff)) : ONE_Q16);
            hold_pod_in  = mem_rdata.pod;
            hold_cost_in = mem_rdata.cost;
            state_in     = S_UP_CHK;
         end
         S_UP_CHK: begin
            if (rem_ff >= {1'b0, den_ff}) begin
               newp_in  = ONE_Q31;
               state_in = S_UP_WR;
            end else begin
               frac_in  = '0;
               cnt_in   = '0;
               state_in = S_UP_DIV;
            end
         end
         S_UP_DIV: begin
            // One quotient bit per cycle; the remainder stays below the divisor.
            if (rem_shift >= {1'b0, den_ff}) begin
               rem_in  = rem_shift - {1'b0, den_ff};
               frac_in = {frac_ff[29:0], 1'b1};
            end else begin
               rem_in  = rem_shift;
               frac_in = {frac_ff[29:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd30) begin
               newp_in  = {1'b0, frac_in};
               state_in = S_UP_WR;
            end
         end
         S_UP_WR: begin
            prod_in = newp_ff * hold_pod_ff;
            if (cur_addr == best_addr) post_in = newp_ff;
            state_in = S_UP_ACC;
         end
         S_UP_ACC: begin
            acc_in = acc_ff + ACCW'(prod_ff);
            if (last_cell) begin
               res_row_in = 4'(best_r_ff);
               res_col_in = 4'(best_c_ff);
               state_in   = S_DONE;
            end else begin
               state_in = S_UP_RD;
            end
            if (c_ff == nc_ff - CNW'(1)) begin
               c_in = '0;
               r_in = r_ff + RNW'(1);
            end else begin
               c_in = c_ff + CNW'(1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_ff;
               rsp_row_in   = res_row_ff;
               rsp_col_in   = res_col_ff;
               rsp_det_in   = (kind_ff == KIND_READ) ? 32'd0 : det_sat;
               rsp_post_in  = post_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rows_ff      <= 5'd16;
         cols_ff      <= 5'd16;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      nr_ff <= nr_in;  nc_ff <= nc_in;  r_ff <= r_in;  c_ff <= c_in;
      best_r_ff <= best_r_in;  best_c_ff <= best_c_in;  have_ff <= have_in;
      best_s_ff <= best_s_in;  best_k_ff <= best_k_in;  s_ff <= s_in;  k_ff <= k_in;
      den_ff <= den_in;  ds_ff <= ds_in;  pa_ff <= pa_in;  pb_ff <= pb_in;
      rem_ff <= rem_in;  frac_ff <= frac_in;  cnt_ff <= cnt_in;
      newp_ff <= newp_in;  post_ff <= post_in;
      hold_pod_ff <= hold_pod_in;  hold_cost_ff <= hold_cost_in;
      prod_ff <= prod_in;  acc_ff <= acc_in;
      kind_ff <= kind_in;  zero_ff <= zero_in;
      res_row_ff <= res_row_in;  res_col_ff <= res_col_in;
      rsp_kind_ff <= rsp_kind_in;  rsp_row_ff <= rsp_row_in;  rsp_col_ff <= rsp_col_in;
      rsp_det_ff <= rsp_det_in;  rsp_post_ff <= rsp_post_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = rsp_kind_ff;
   assign rsp_searched_row   = rsp_row_ff;
   assign rsp_searched_col   = rsp_col_ff;
   assign rsp_detection_prob = rsp_det_ff;
   assign rsp_cell_posterior = rsp_post_ff;

   a_write_when_allowed: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_IDLE || state_ff == S_UP_WR))
      else $error("cell store written outside a write item or update step");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UP_DIV) |-> (cnt_ff <= 5'd30))
      else $error("divider ran past its last quotient bit");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UP_DIV) |-> (rem_ff < {1'b0, den_ff}))
      else $error("divider remainder not below divisor");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("result raised outside the finishing step");

endmodule
